// ----- sv/linear_probe_hash_table_macros.svh -----
// Assertion macros shared by the hash table RTL.
// No dependencies; included by the controller and the datapath.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lpht_pkg.sv -----
// Types and constants of the linear probing hash table.
// No dependencies; used by the top level, the controller and the datapath.
package lpht_pkg;

  localparam int OP_BITS         = 2;
  localparam int KEY_BITS        = 32;
  localparam int VALUE_IN_BITS   = 32;
  localparam int STATUS_BITS     = 2;
  localparam int VALUE_OUT_BITS  = 32;
  localparam int SLOT_INDEX_BITS = 6;

  // Home slot reduction: reciprocal multiply cycle, then remainder cycle.
  localparam int MOD_STEPS = 2;
  localparam int MOD_CW    = $clog2(MOD_STEPS);

  localparam logic [OP_BITS-1:0] OP_SET    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_GET    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_BITS-1:0] STS_DONE = 2'd0;
  localparam logic [STATUS_BITS-1:0] STS_MISS = 2'd1;
  localparam logic [STATUS_BITS-1:0] STS_FULL = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]       op;
    logic [KEY_BITS-1:0]      key_hash;
    logic [VALUE_IN_BITS-1:0] value_in;
  } lpht_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]     status;
    logic [VALUE_OUT_BITS-1:0]  value_out;
    logic [SLOT_INDEX_BITS-1:0] slot_index;
  } lpht_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;
    logic accept;
    logic mod_step;
    logic probe;
    logic out_load;
  } lpht_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic bad_op;
    logic mod_last;
    logic resolve;
  } lpht_sts_t;

endpackage

// ----- sv/linear_probe_hash_table.sv -----
// Top level of the linear probing hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+----------------------------------
//   in_     | request   | in_valid, in_stall | op, key_hash, value_in
//   out_    | result    | out_valid,out_stall| status, value_out, slot_index
//
// After reset a clearing pass walks the tag RAM, one slot a cycle, through every
// slot; in_stall stays high during it.
// A request is accepted, then passes through the home slot reduction
// (reciprocal multiply, then the remainder), then takes one tag RAM read a cycle
// along the probe chain until the home slot or a later slot decides or the
// scan has wrapped the whole table; it then loads the output register when free.
// An unused op code skips reduction and probe.
// The output register holds one result; a new request is taken while it
// waits, and that request parks before delivery until out_stall drops.
module linear_probe_hash_table #(
  parameter int SLOTS      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpht_pkg::lpht_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::lpht_rsp_t out_data
);
  import lpht_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  lpht_cmd_t cmd;
  lpht_sts_t sts;

  // Sequencer: owns the handshake and the step order of each request.
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds the request, reduces the key, probes and updates slots.
  lpht_dp #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- sv/lpht_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/lpht_ctrl.sv -----
// Sequencer of the hash table: clearing pass, accept, reduce, probe, deliver.
// Depends on lpht_pkg and the assertion macro header.
`include "linear_probe_hash_table_macros.svh"

module lpht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_cmd_t cmd
);
  import lpht_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.bad_op ? ST_DONE : ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.resolve) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LPHT_ASSERT_IMPL(a_resolve_in_probe, clk, rst_n, sts.resolve, state_r == ST_PROBE, "resolve outside probe")
  `LPHT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, cmd.accept, state_r != ST_IDLE, "idle after accept")
  `LPHT_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_r && state_r == ST_IDLE, "load lost")

endmodule

// ----- sv/lpht_dp.sv -----
// Datapath of the hash table: home slot reduction, slot probe, tag and value RAMs.
// Depends on lpht_pkg, lpht_ram and the assertion macro header.
`include "linear_probe_hash_table_macros.svh"

module lpht_dp #(
  parameter int SLOTS      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpht_pkg::lpht_req_t in_data,
  input  lpht_pkg::lpht_cmd_t cmd,
  output lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_rsp_t out_data
);
  import lpht_pkg::*;

  localparam int IW     = $clog2(SLOTS);
  localparam int CW     = IW + 1;
  localparam int TAG_W  = KEY_BITS + 1;
  localparam int PROD_W = 2 * KEY_BITS + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_W   = CW'(SLOTS);
  // Rounded-up reciprocal of SLOTS; the quotient is exact for every 32-bit key.
  localparam logic [KEY_BITS:0] RECIP =
    (KEY_BITS + 1)'((64'd1 << (KEY_BITS + IW)) / SLOTS + 1);

  // Request and reduction registers
  logic [OP_BITS-1:0]    op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_BITS-1:0]   quot_r;
  logic [MOD_CW-1:0]     mod_cnt_r;
  logic [PROD_W-1:0]     mod_prod;
  logic [KEY_BITS-1:0]   mod_quot;
  logic [IW-1:0]         mod_rem;

  // Probe registers
  logic [IW-1:0] rd_ptr_r;
  logic [CW-1:0] iss_cnt_r;
  logic          chk_vld_r, chk_vld_nxt;
  logic          chk_home_r;
  logic          chk_last_r;
  logic [IW-1:0] chk_idx_r;
  logic [IW-1:0] clr_ptr_r, clr_ptr_nxt;
  logic [IW-1:0] ptr_adv;
  logic          issue;

  // Slot compare
  logic [TAG_W-1:0]      tag_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  tag_full;
  logic                  tag_eq;
  logic                  is_set;
  logic                  hit;
  logic                  stop_miss;
  logic                  commit_set;
  logic                  commit_rm;
  lpht_rsp_t             res_r, res_nxt, out_r;

  // Tag RAM write port
  logic              tag_we;
  logic [IW-1:0]     tag_waddr;
  logic [TAG_W-1:0]  tag_wdata;

  // Home slot: quotient by reciprocal multiply, then key minus quotient times SLOTS.
  assign mod_prod = PROD_W'(key_r) * PROD_W'(RECIP);
  assign mod_quot = KEY_BITS'(mod_prod >> (KEY_BITS + IW));
  assign mod_rem  = IW'(key_r - KEY_BITS'(quot_r * KEY_BITS'(SLOTS)));

  assign sts.mod_last   = (mod_cnt_r == MOD_CW'(MOD_STEPS - 1));
  assign sts.clear_last = (clr_ptr_r == LAST_SLOT);
  assign sts.bad_op     = !(in_data.op inside {OP_SET, OP_GET, OP_REMOVE});

  // Decide on the slot whose tag just came back.
  assign tag_full  = tag_rd[TAG_W-1];
  assign tag_eq    = tag_full && (tag_rd[KEY_BITS-1:0] == key_r);
  assign is_set    = (op_r == OP_SET);
  assign hit       = is_set ? (!tag_full || (chk_home_r && tag_eq)) : tag_eq;
  assign stop_miss = !is_set && chk_home_r && !tag_full;
  assign sts.resolve = chk_vld_r && (hit || stop_miss || chk_last_r);

  assign commit_set = sts.resolve && hit && is_set;
  assign commit_rm  = sts.resolve && hit && (op_r == OP_REMOVE);

  always_comb begin
    res_nxt.status     = hit ? STS_DONE : (is_set ? STS_FULL : STS_MISS);
    res_nxt.value_out  = (hit && op_r == OP_GET) ? VALUE_OUT_BITS'(val_rd) : '0;
    res_nxt.slot_index = hit ? SLOT_INDEX_BITS'(chk_idx_r) : '0;
  end

  // Read one slot a cycle until the item resolves or every slot was read.
  assign issue   = cmd.probe && (iss_cnt_r != SLOTS_W) && !sts.resolve;
  assign ptr_adv = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;

  assign chk_vld_nxt = issue;
  assign clr_ptr_nxt = cmd.clear ? clr_ptr_r + 1'b1 : clr_ptr_r;

  assign tag_we    = cmd.clear || commit_set || commit_rm;
  assign tag_waddr = cmd.clear ? clr_ptr_r : chk_idx_r;
  assign tag_wdata = commit_set ? {1'b1, key_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      clr_ptr_r <= clr_ptr_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_data.op;
      key_r     <= in_data.key_hash;
      val_r     <= VALUE_BITS'(in_data.value_in);
      mod_cnt_r <= '0;
      res_r     <= '{status: STS_MISS, value_out: '0, slot_index: '0};
    end
    if (cmd.mod_step) begin
      quot_r    <= mod_quot;
      mod_cnt_r <= mod_cnt_r + 1'b1;
      if (sts.mod_last) begin
        rd_ptr_r  <= mod_rem;
        iss_cnt_r <= '0;
      end
    end
    if (issue) begin
      chk_idx_r  <= rd_ptr_r;
      chk_home_r <= (iss_cnt_r == '0);
      chk_last_r <= (iss_cnt_r == SLOTS_W - 1'b1);
      rd_ptr_r   <= ptr_adv;
      iss_cnt_r  <= iss_cnt_r + 1'b1;
    end
    if (sts.resolve) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  lpht_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (tag_rd)
  );

  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (commit_set),
    .waddr (chk_idx_r),
    .wdata (val_r),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (val_rd)
  );

  `LPHT_ASSERT_IMPL(a_no_commit_in_clear, clk, rst_n, cmd.clear, !(commit_set || commit_rm), "write during clear")
  `LPHT_ASSERT_NEXT(a_home_in_range, clk, rst_n, cmd.mod_step && sts.mod_last, rd_ptr_r <= LAST_SLOT, "home slot out of range")
  `LPHT_ASSERT_NEXT(a_issue_checks, clk, rst_n, issue, chk_vld_r, "issued read not checked")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for linear_probe_hash_table.
// Depends on lpht_pkg and the RTL; runs directed rows, then random request traffic
// checked against an in-bench model of the slot array.
`timescale 1ns / 1ps

module testbench;
  import lpht_pkg::*;

  localparam int SLOT_COUNT  = 64;
  localparam int CYCLE_LIMIT = 400000;
  // Op code with no meaning to the block; it must miss and leave the table alone.
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef enum { MIXED_TRAFFIC, FILL_TRAFFIC, DRAIN_TRAFFIC } traffic_t;

  typedef struct {
    lpht_req_t req;
    bit        typed;
    lpht_rsp_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lpht_req_t in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lpht_rsp_t out_data;

  // Shadow copy of the slot array, updated as each request is accepted.
  bit          occupied [SLOT_COUNT];
  logic [31:0] tag      [SLOT_COUNT];
  logic [31:0] stored   [SLOT_COUNT];

  lpht_rsp_t pending_results [$];
  plan_row_t directed_plan [$];
  int        errors       = 0;
  int        results_seen = 0;
  int        cycles       = 0;
  bit        quiet        = 1'b0;

  linear_probe_hash_table #(
    .SLOTS      (SLOT_COUNT),
    .VALUE_BITS (32)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset low from the start, then release it on a falling edge, once for the whole run.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Apply one request to the shadow table and return the result it must produce.
  // Set: home slot if empty or same hash, else first empty slot after it.
  // Get/remove: home slot must be full; then scan the rest for a full, equal slot.
  function automatic lpht_rsp_t lookup_and_update(lpht_req_t r);
    lpht_rsp_t rsp;
    int        home;
    int        slot;
    int        hit;
    int        k;
    rsp.status     = STS_MISS;
    rsp.value_out  = '0;
    rsp.slot_index = '0;
    home = int'(r.key_hash % SLOT_COUNT);
    hit  = -1;
    case (r.op)
      OP_SET: begin
        if (!occupied[home] || tag[home] == r.key_hash) hit = home;
        for (k = 1; k < SLOT_COUNT && hit < 0; k++) begin
          slot = (home + k) % SLOT_COUNT;
          if (!occupied[slot]) hit = slot;
        end
        if (hit < 0) begin
          rsp.status = STS_FULL;
        end else begin
          occupied[hit]  = 1'b1;
          tag[hit]       = r.key_hash;
          stored[hit]    = r.value_in;
          rsp.status     = STS_DONE;
          rsp.slot_index = SLOT_INDEX_BITS'(hit);
        end
      end
      OP_GET, OP_REMOVE: begin
        // An empty home slot ends the search, even with a match further on.
        if (occupied[home]) begin
          if (tag[home] == r.key_hash) hit = home;
          for (k = 1; k < SLOT_COUNT && hit < 0; k++) begin
            slot = (home + k) % SLOT_COUNT;
            if (occupied[slot] && tag[slot] == r.key_hash) hit = slot;
          end
        end
        if (hit >= 0) begin
          rsp.status     = STS_DONE;
          rsp.slot_index = SLOT_INDEX_BITS'(hit);
          if (r.op == OP_GET) begin
            rsp.value_out = stored[hit];
          end else begin
            occupied[hit] = 1'b0;
            tag[hit]      = '0;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_result(lpht_rsp_t got);
    lpht_rsp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result status", 32'(got.status), 32'(got.status));
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.value_out !== want.value_out)
        report_mismatch("value_out", got.value_out, want.value_out);
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
    end
    results_seen++;
  endtask

  task automatic add_row(logic [OP_BITS-1:0] op, logic [31:0] key, logic [31:0] value,
                         bit typed, logic [STATUS_BITS-1:0] status,
                         logic [31:0] value_out, logic [SLOT_INDEX_BITS-1:0] index);
    plan_row_t row;
    row.req.op          = op;
    row.req.key_hash    = key;
    row.req.value_in    = value;
    row.typed           = typed;
    row.want.status     = status;
    row.want.value_out  = value_out;
    row.want.slot_index = index;
    directed_plan.push_back(row);
  endtask

  // Hash keys: half land on a cluster of homes that straddles the wrap point,
  // and non-fresh keys mostly reuse a stored hash (sometimes only its home bits).
  function automatic logic [31:0] draw_key(bit fresh);
    logic [31:0] k;
    int          s;
    int          tries;
    k = $urandom;
    if ($urandom_range(0, 1) == 0) k[5:0] = 6'(60 + $urandom_range(0, 7));
    if (!fresh) begin
      for (tries = 0; tries < 4; tries++) begin
        s = $urandom_range(0, SLOT_COUNT - 1);
        if (occupied[s]) begin
          k = ($urandom_range(0, 4) == 0) ? {k[31:6], tag[s][5:0]} : tag[s];
          tries = 4;
        end
      end
    end
    return k;
  endfunction

  function automatic lpht_req_t draw_request(traffic_t mode);
    lpht_req_t r;
    int        roll;
    int        set_pct;
    int        get_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      FILL_TRAFFIC:  begin set_pct = 70; get_pct = 15; end
      DRAIN_TRAFFIC: begin set_pct = 20; get_pct = 20; end
      default:       begin set_pct = 40; get_pct = 35; end
    endcase
    if (roll < set_pct)                 r.op = OP_SET;
    else if (roll < set_pct + get_pct) r.op = OP_GET;
    else if (roll < 96)                r.op = OP_REMOVE;
    else                               r.op = OP_UNUSED;
    r.key_hash = draw_key(r.op == OP_SET &&
                          (mode == FILL_TRAFFIC || $urandom_range(0, 2) != 0));
    r.value_in = $urandom;
    return r;
  endfunction

  // Offer one request, optionally after an idle burst, and hold it until taken.
  task automatic offer_request(lpht_req_t r, bit typed, lpht_rsp_t want);
    lpht_rsp_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = lookup_and_update(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_traffic(traffic_t mode, int count);
    lpht_rsp_t none;
    none = '0;
    repeat (count) offer_request(draw_request(mode), 1'b0, none);
  endtask

  // Request side: directed rows first, then random traffic in phases.
  initial begin : sender
    for (int i = 0; i < SLOT_COUNT; i++) begin
      occupied[i] = 1'b0;
      tag[i]      = '0;
      stored[i]   = '0;
    end

    // Rows with a typed result are fixed by an empty table and the rows before them, or by a bad op code.
    add_row(OP_GET,    32'h0000_0000, 32'h0000_0000, 1, STS_MISS, 32'h0, 6'd0);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, STS_MISS, 32'h0, 6'd0);
    add_row(OP_SET,    32'h0000_0000, 32'h0000_0000, 1, STS_DONE, 32'h0, 6'd0);
    add_row(OP_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STS_DONE, 32'h0, 6'd63);
    add_row(OP_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1, STS_DONE, 32'hFFFF_FFFF, 6'd63);
    add_row(OP_GET,    32'h0000_0000, 32'hFFFF_FFFF, 1, STS_DONE, 32'h0, 6'd0);
    // Collide on home zero and probe forward.
    add_row(OP_SET,    32'h0000_0040, 32'h0000_1234, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_SET,    32'h0000_0080, 32'h5555_AAAA, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_GET,    32'h0000_0080, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    // Same hash in the home slot: overwrite in place.
    add_row(OP_SET,    32'h0000_0000, 32'hA5A5_5A5A, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_UNUSED, 32'h0000_0040, 32'h0000_0000, 1, STS_MISS, 32'h0, 6'd0);
    // Emptied home slot hides the entry that probed past it.
    add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_GET,    32'h0000_0040, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    // Home 63 taken: probe wraps to slot zero, and the lookup wraps too.
    add_row(OP_SET,    32'h0000_007F, 32'h0F0F_F0F0, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_GET,    32'h0000_007F, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_GET,    32'h0000_007F, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    // A freed slot in the chain lets a duplicate hash land behind the first copy.
    add_row(OP_REMOVE, 32'h0000_0080, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_SET,    32'h0000_0040, 32'hDEAD_BEEF, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_GET,    32'h0000_0040, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    // Empty slots carry hash zero and must never match key zero.
    add_row(OP_GET,    32'h0000_0000, 32'h0000_0000, 0, STS_DONE, 32'h0, 6'd0);
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STS_MISS, 32'h0, 6'd0);

    wait (rst_n);
    foreach (directed_plan[i])
      offer_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);

    run_traffic(MIXED_TRAFFIC, 250);

    // Pause with nothing offered until every result is back.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // Fill past capacity to hit table-full and whole-table scans, then drain.
    run_traffic(FILL_TRAFFIC, 100);
    run_traffic(DRAIN_TRAFFIC, 100);

    // Final stretch runs back to back on both sides.
    quiet = 1'b1;
    run_traffic(MIXED_TRAFFIC, 150);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 16) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_results.size()), 32'h0);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: decide stall at the falling edge, check at the rising edge.
  // One long hold-off lets requests pile up until the block stalls its input.
  initial begin : receiver
    int hold_left;
    bit long_done;
    hold_left = 0;
    long_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && results_seen >= 120) begin
        hold_left = 300;
        long_done = 1'b1;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 6);
      end
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result(out_data);
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
